// ===== design/cbso_pkg.sv =====
// Shared constants for the center box select / overlap check block.
// Register indexes, threshold format and config port sizing.
// No dependencies.
package cbso_pkg;

    // Threshold is unsigned Q16, 17 bits so that 1.0 fits
    localparam int RATE_W    = 17;
    localparam int RATE_FRAC = 16;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;

    // Register index map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_TARGET_X     = 3'd2,
        REG_TARGET_Y     = 3'd3,
        REG_TARGET_W     = 3'd4,
        REG_TARGET_H     = 3'd5,
        REG_MIN_RATE     = 3'd6
    } cfg_reg_t;

    // Reset frame size
    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

endpackage

// ===== design/center_box_select_overlap_check.sv =====
// A box that does not close the frame keeps the block busy through S_DX, S_DY and S_CMP;
// a closing request with a box goes on through S_AREA, S_OVL, S_THR and S_FIN, one without
// a box to S_AREA (S_FIN if the frame held no box). No request is taken outside S_IDLE. A
// single shared multiplier squares dx, dy and forms the overlap, area and threshold products.
// Reset (rst_n, async, active low) loads the register defaults and clears the frame state.
// Uses cbso_pkg and cbso_mul.
module center_box_select_overlap_check #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [cbso_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((COORD_BITS > cbso_pkg::RATE_W) ? COORD_BITS
                                                   : cbso_pkg::RATE_W)-1:0] cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COORD_BITS:0]             box_x,
    input  logic signed [COORD_BITS:0]             box_y,
    input  logic [COORD_BITS-1:0]                  box_w,
    input  logic [COORD_BITS-1:0]                  box_h,
    input  logic                                   box_valid,
    input  logic                                   last_box,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   face_found,
    output logic                                   in_box,
    output logic signed [COORD_BITS:0]             face_x,
    output logic signed [COORD_BITS:0]             face_y,
    output logic [COORD_BITS-1:0]                  face_w,
    output logic [COORD_BITS-1:0]                  face_h
);

    localparam int C     = COORD_BITS;
    localparam int D_W   = C + 3;              // signed center offset
    localparam int AD_W  = C + 2;              // magnitude of offset
    localparam int DW    = 2 * C + 5;          // squared distance
    localparam int MAW   = 2 * C;
    localparam int MBW   = (C + 2 > cbso_pkg::RATE_W) ? C + 2 : cbso_pkg::RATE_W;
    localparam int PW    = MAW + MBW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DX,
        S_DY,
        S_CMP,
        S_AREA,
        S_OVL,
        S_THR,
        S_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [C-1:0]                  image_w_reg, image_h_reg;
    logic [C-1:0]                  tgt_x_reg, tgt_y_reg, tgt_w_reg, tgt_h_reg;
    logic [cbso_pkg::RATE_W-1:0]   rate_reg;

    // Request capture
    logic                          last_reg;
    logic signed [C:0]             cur_x_reg, cur_y_reg;
    logic [C-1:0]                  cur_w_reg, cur_h_reg;
    logic [AD_W-1:0]               adx_reg, ady_reg;

    // Frame state
    logic                          have_best_reg;
    logic [DW-1:0]                 best_dist_reg;
    logic signed [C:0]             best_x_reg, best_y_reg;
    logic [C-1:0]                  best_w_reg, best_h_reg;

    // Work registers
    logic [DW-1:0]                 dx2_reg;
    logic [C-1:0]                  ow_reg, oh_reg;
    logic [MAW-1:0]                area_reg;
    logic [MAW-1:0]                ovl_reg;

    // Output registers
    logic                          out_valid_reg;
    logic                          face_found_reg, in_box_reg;
    logic signed [C:0]             face_x_reg, face_y_reg;
    logic [C-1:0]                  face_w_reg, face_h_reg;

    // Multiplier hookup
    logic                          mul_en;
    logic [MAW-1:0]                mul_a;
    logic [MBW-1:0]                mul_b;
    logic [PW-1:0]                 prod;

    cbso_mul #(
        .A_W (MAW),
        .B_W (MBW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Center offsets in half pixels for the incoming box
    logic signed [D_W-1:0] dx, dy;
    logic [D_W-1:0]        dx_mag, dy_mag;

    always_comb
    begin
        dx = $signed({box_x[C], box_x, 1'b0}) + $signed({3'b000, box_w})
             - $signed({3'b000, image_w_reg});
        dy = $signed({box_y[C], box_y, 1'b0}) + $signed({3'b000, box_h})
             - $signed({3'b000, image_h_reg});
        dx_mag = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
        dy_mag = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    end

    // Overlap spans of the chosen box with the target
    logic signed [D_W-1:0] s1x, e1x, s2x, e2x, lox, hix, dox;
    logic signed [D_W-1:0] s1y, e1y, s2y, e2y, loy, hiy, doy;
    logic [C-1:0]          ow_clamp, oh_clamp;

    always_comb
    begin
        s1x = D_W'(best_x_reg);
        e1x = D_W'(best_x_reg) + $signed({3'b000, best_w_reg});
        s2x = $signed({3'b000, tgt_x_reg});
        e2x = $signed({3'b000, tgt_x_reg}) + $signed({3'b000, tgt_w_reg});
        lox = (s1x > s2x) ? s1x : s2x;
        hix = (e1x < e2x) ? e1x : e2x;
        dox = hix - lox;
        ow_clamp = (dox > 0) ? dox[C-1:0] : '0;

        s1y = D_W'(best_y_reg);
        e1y = D_W'(best_y_reg) + $signed({3'b000, best_h_reg});
        s2y = $signed({3'b000, tgt_y_reg});
        e2y = $signed({3'b000, tgt_y_reg}) + $signed({3'b000, tgt_h_reg});
        loy = (s1y > s2y) ? s1y : s2y;
        hiy = (e1y < e2y) ? e1y : e2y;
        doy = hiy - loy;
        oh_clamp = (doy > 0) ? doy[C-1:0] : '0;
    end

    // Multiplier operand select per step
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_DX:
            begin
                mul_en = 1'b1;
                mul_a  = MAW'(adx_reg);
                mul_b  = MBW'(adx_reg);
            end
            S_DY:
            begin
                mul_en = 1'b1;
                mul_a  = MAW'(ady_reg);
                mul_b  = MBW'(ady_reg);
            end
            S_AREA:
            begin
                mul_en = 1'b1;
                mul_a  = MAW'(best_w_reg);
                mul_b  = MBW'(best_h_reg);
            end
            S_OVL:
            begin
                mul_en = 1'b1;
                mul_a  = MAW'(ow_reg);
                mul_b  = MBW'(oh_reg);
            end
            S_THR:
            begin
                mul_en = 1'b1;
                mul_a  = area_reg;
                mul_b  = MBW'(rate_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Distance of the current box and the threshold test
    logic [DW-1:0] dist_sum;
    logic          take_box;
    logic [PW-1:0] ovl_scaled;
    logic          over_thr;

    always_comb
    begin
        dist_sum   = dx2_reg + prod[DW-1:0];
        take_box   = !have_best_reg || (dist_sum < best_dist_reg);
        ovl_scaled = PW'({ovl_reg, {cbso_pkg::RATE_FRAC{1'b0}}});
        over_thr   = ovl_scaled > prod;
    end

    // Result load once the output register is free
    logic out_load;

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // Sequencer, frame state, config and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            image_w_reg    <= C'(cbso_pkg::IMAGE_WIDTH_RESET);
            image_h_reg    <= C'(cbso_pkg::IMAGE_HEIGHT_RESET);
            tgt_x_reg      <= '0;
            tgt_y_reg      <= '0;
            tgt_w_reg      <= '0;
            tgt_h_reg      <= '0;
            rate_reg       <= cbso_pkg::RATE_RESET;
            have_best_reg  <= 1'b0;
            best_dist_reg  <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_w_reg     <= '0;
            best_h_reg     <= '0;
            out_valid_reg  <= 1'b0;
            face_found_reg <= 1'b0;
            in_box_reg     <= 1'b0;
            face_x_reg     <= '0;
            face_y_reg     <= '0;
            face_w_reg     <= '0;
            face_h_reg     <= '0;
            last_reg       <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_w_reg      <= '0;
            cur_h_reg      <= '0;
            adx_reg        <= '0;
            ady_reg        <= '0;
            dx2_reg        <= '0;
            ow_reg         <= '0;
            oh_reg         <= '0;
            area_reg       <= '0;
            ovl_reg        <= '0;
        end
        else
        begin
            // register writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    cbso_pkg::REG_IMAGE_WIDTH:  image_w_reg <= cfg_data[C-1:0];
                    cbso_pkg::REG_IMAGE_HEIGHT: image_h_reg <= cfg_data[C-1:0];
                    cbso_pkg::REG_TARGET_X:     tgt_x_reg   <= cfg_data[C-1:0];
                    cbso_pkg::REG_TARGET_Y:     tgt_y_reg   <= cfg_data[C-1:0];
                    cbso_pkg::REG_TARGET_W:     tgt_w_reg   <= cfg_data[C-1:0];
                    cbso_pkg::REG_TARGET_H:     tgt_h_reg   <= cfg_data[C-1:0];
                    cbso_pkg::REG_MIN_RATE:
                        rate_reg <= cfg_data[cbso_pkg::RATE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // result loaded, or taken downstream
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= last_box;
                        cur_x_reg <= box_x;
                        cur_y_reg <= box_y;
                        cur_w_reg <= box_w;
                        cur_h_reg <= box_h;
                        adx_reg   <= dx_mag[AD_W-1:0];
                        ady_reg   <= dy_mag[AD_W-1:0];
                        if (box_valid)
                        begin
                            state_reg <= S_DX;
                        end
                        else if (last_box)
                        begin
                            state_reg <= have_best_reg ? S_AREA : S_FIN;
                        end
                    end
                end
                S_DX:
                begin
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    dx2_reg   <= prod[DW-1:0];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    // earlier box wins a tie
                    if (take_box)
                    begin
                        have_best_reg <= 1'b1;
                        best_dist_reg <= dist_sum;
                        best_x_reg    <= cur_x_reg;
                        best_y_reg    <= cur_y_reg;
                        best_w_reg    <= cur_w_reg;
                        best_h_reg    <= cur_h_reg;
                    end
                    state_reg <= last_reg ? S_AREA : S_IDLE;
                end
                S_AREA:
                begin
                    ow_reg    <= ow_clamp;
                    oh_reg    <= oh_clamp;
                    state_reg <= S_OVL;
                end
                S_OVL:
                begin
                    area_reg  <= prod[MAW-1:0];
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    ovl_reg   <= prod[MAW-1:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // load result once the output register is free
                    if (out_load)
                    begin
                        face_found_reg <= have_best_reg;
                        in_box_reg     <= have_best_reg && over_thr;
                        face_x_reg     <= have_best_reg ? best_x_reg : '0;
                        face_y_reg     <= have_best_reg ? best_y_reg : '0;
                        face_w_reg     <= have_best_reg ? best_w_reg : '0;
                        face_h_reg     <= have_best_reg ? best_h_reg : '0;
                        have_best_reg  <= 1'b0;
                        best_dist_reg  <= '0;
                        best_x_reg     <= '0;
                        best_y_reg     <= '0;
                        best_w_reg     <= '0;
                        best_h_reg     <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign face_found = face_found_reg;
    assign in_box     = in_box_reg;
    assign face_x     = face_x_reg;
    assign face_y     = face_y_reg;
    assign face_w     = face_w_reg;
    assign face_h     = face_h_reg;

endmodule

// ===== design/cbso_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Holds its product while the enable is low.
// No dependencies.
module cbso_mul #(
    parameter int A_W = 24,
    parameter int B_W = 17
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]   p
);

    logic [A_W+B_W-1:0] p_reg;

    // One product per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign p = p_reg;

endmodule

// ===== tb/tb_center_box_select_overlap_check.sv =====
`timescale 1ns / 100ps
// Testbench for center_box_select_overlap_check: frames of boxes with random gaps and stalls.
// Results are checked against an in-bench model of nearest-center pick and overlap test.
// Depends on cbso_pkg and the block's RTL.
module tb_center_box_select_overlap_check;

    localparam int CB = 12;
    localparam int CFG_W = (CB > cbso_pkg::RATE_W) ? CB : cbso_pkg::RATE_W;
    localparam int RANDOM_ITEMS = 1400;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic                 face_found;
        logic                 in_box;
        logic signed [CB:0]   x;
        logic signed [CB:0]   y;
        logic [CB-1:0]        w;
        logic [CB-1:0]        h;
    } face_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [cbso_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CB:0]   box_x;
    logic signed [CB:0]   box_y;
    logic [CB-1:0]        box_w;
    logic [CB-1:0]        box_h;
    logic                 box_valid;
    logic                 last_box;
    logic                 out_valid;
    logic                 out_stall;
    logic                 face_found;
    logic                 in_box;
    logic signed [CB:0]   face_x;
    logic signed [CB:0]   face_y;
    logic [CB-1:0]        face_w;
    logic [CB-1:0]        face_h;

    // model copy of the registers
    logic [CB-1:0]        img_w, img_h, tgt_x, tgt_y, tgt_w, tgt_h;
    logic [cbso_pkg::RATE_W-1:0] min_rate;

    // model copy of the frame state
    logic                 fr_have;
    longint unsigned      fr_dist;
    logic signed [CB:0]   fr_x, fr_y;
    logic [CB-1:0]        fr_w, fr_h;

    face_result_t         pending_faces[$];

    int errors = 0;
    int n_items = 0;
    int n_counted = 0;
    int n_frames = 0;
    int n_faces = 0;
    int n_inbox = 0;
    int n_cfg = 0;

    // sender pacing and receiver stall controls
    bit  gaps_on = 1'b1;
    int  burst_left = 0;
    int  stall_pct = 0;
    int  stall_run = 0;
    int  hold_left = 0;

    center_box_select_overlap_check #(.COORD_BITS(CB)) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_w      (box_w),
        .box_h      (box_h),
        .box_valid  (box_valid),
        .last_box   (last_box),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .face_found (face_found),
        .in_box     (in_box),
        .face_x     (face_x),
        .face_y     (face_y),
        .face_w     (face_w),
        .face_h     (face_h)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Nearest-center tracking per frame; on the closing request, predict the result
    function automatic void track_nearest_box(input logic signed [CB:0] x,
                                              input logic signed [CB:0] y,
                                              input logic [CB-1:0] w,
                                              input logic [CB-1:0] h,
                                              input logic v,
                                              input logic last);
        longint          dx, dy, lo, hi, ow, oh;
        longint unsigned sq_dist, ovl, area, rate_l;
        face_result_t    r;
        if (v)
        begin
            // half-pixel offsets from the image center
            dx = 2 * longint'(x) + longint'(w) - longint'(img_w);
            dy = 2 * longint'(y) + longint'(h) - longint'(img_h);
            sq_dist = dx * dx + dy * dy;
            // strict compare: the earlier box wins a tie
            if (!fr_have || sq_dist < fr_dist)
            begin
                fr_have = 1'b1;
                fr_dist = sq_dist;
                fr_x = x;
                fr_y = y;
                fr_w = w;
                fr_h = h;
            end
        end
        if (last)
        begin
            r = '0;
            if (fr_have)
            begin
                lo = (longint'(fr_x) > longint'(tgt_x)) ? longint'(fr_x) : longint'(tgt_x);
                hi = ((longint'(fr_x) + longint'(fr_w)) < (longint'(tgt_x) + longint'(tgt_w)))
                     ? longint'(fr_x) + longint'(fr_w) : longint'(tgt_x) + longint'(tgt_w);
                ow = hi - lo;
                lo = (longint'(fr_y) > longint'(tgt_y)) ? longint'(fr_y) : longint'(tgt_y);
                hi = ((longint'(fr_y) + longint'(fr_h)) < (longint'(tgt_y) + longint'(tgt_h)))
                     ? longint'(fr_y) + longint'(fr_h) : longint'(tgt_y) + longint'(tgt_h);
                oh = hi - lo;
                r.face_found = 1'b1;
                // overlap / area > rate / 2^16, cross-multiplied
                if (ow > 0 && oh > 0)
                begin
                    ovl = ow * oh;
                    area = longint'(fr_w) * longint'(fr_h);
                    rate_l = min_rate;
                    r.in_box = ((ovl << cbso_pkg::RATE_FRAC) > rate_l * area);
                end
                r.x = fr_x;
                r.y = fr_y;
                r.w = fr_w;
                r.h = fr_h;
                n_faces++;
                if (r.in_box)
                    n_inbox++;
            end
            pending_faces.push_back(r);
            n_frames++;
            fr_have = 1'b0;
            fr_dist = 0;
            fr_x = '0;
            fr_y = '0;
            fr_w = '0;
            fr_h = '0;
        end
    endfunction

    // One register write, mirrored into the model
    task automatic cfg_write(input cbso_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            cbso_pkg::REG_IMAGE_WIDTH:  img_w = val[CB-1:0];
            cbso_pkg::REG_IMAGE_HEIGHT: img_h = val[CB-1:0];
            cbso_pkg::REG_TARGET_X:     tgt_x = val[CB-1:0];
            cbso_pkg::REG_TARGET_Y:     tgt_y = val[CB-1:0];
            cbso_pkg::REG_TARGET_W:     tgt_w = val[CB-1:0];
            cbso_pkg::REG_TARGET_H:     tgt_h = val[CB-1:0];
            cbso_pkg::REG_MIN_RATE:     min_rate = val[cbso_pkg::RATE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    task automatic set_config(input int iw, input int ih, input int tx, input int ty,
                              input int tw, input int th, input int rate);
        cfg_write(cbso_pkg::REG_IMAGE_WIDTH, iw[CFG_W-1:0]);
        cfg_write(cbso_pkg::REG_IMAGE_HEIGHT, ih[CFG_W-1:0]);
        cfg_write(cbso_pkg::REG_TARGET_X, tx[CFG_W-1:0]);
        cfg_write(cbso_pkg::REG_TARGET_Y, ty[CFG_W-1:0]);
        cfg_write(cbso_pkg::REG_TARGET_W, tw[CFG_W-1:0]);
        cfg_write(cbso_pkg::REG_TARGET_H, th[CFG_W-1:0]);
        cfg_write(cbso_pkg::REG_MIN_RATE, rate[CFG_W-1:0]);
    endtask

    // Offer one request and hold it until accepted
    task automatic send_box(input logic signed [CB:0] x, input logic signed [CB:0] y,
                            input logic [CB-1:0] w, input logic [CB-1:0] h,
                            input logic v, input logic last);
        @(negedge clk);
        in_valid  <= 1'b1;
        box_x     <= x;
        box_y     <= y;
        box_w     <= w;
        box_h     <= h;
        box_valid <= v;
        last_box  <= last;
        do
            @(posedge clk);
        while (in_stall);
        track_nearest_box(x, y, w, h, v, last);
        n_items++;
        if (v || last)
            n_counted++;
    endtask

    task automatic idle_gap(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Bursts of random length with random gaps in between
    task automatic pace();
        if (gaps_on && burst_left == 0)
        begin
            idle_gap($urandom_range(1, 8));
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stop sending and wait until the block has delivered everything and gone idle
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_faces.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Box drawn full range, around the target, or around the image center
    task automatic random_box(output logic signed [CB:0] x, output logic signed [CB:0] y,
                              output logic [CB-1:0] w, output logic [CB-1:0] h);
        int sel, xi, yi, wi, hi;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            xi = $urandom;
            yi = $urandom;
            wi = $urandom;
            hi = $urandom;
        end
        else if (sel < 7)
        begin
            wi = $urandom_range(0, int'(tgt_w) + 8);
            hi = $urandom_range(0, int'(tgt_h) + 8);
            xi = int'(tgt_x) - wi + int'($urandom_range(0, int'(tgt_w) + wi));
            yi = int'(tgt_y) - hi + int'($urandom_range(0, int'(tgt_h) + hi));
        end
        else
        begin
            wi = $urandom_range(1, 64);
            hi = $urandom_range(1, 64);
            xi = (int'(img_w) - wi) / 2 + int'($urandom_range(0, 4)) - 2;
            yi = (int'(img_h) - hi) / 2 + int'($urandom_range(0, 4)) - 2;
        end
        x = xi[CB:0];
        y = yi[CB:0];
        w = wi[CB-1:0];
        h = hi[CB-1:0];
    endtask

    // Directed: field extremes, empty frame, ties, ignored requests, threshold corners
    task automatic test_directed();
        // defaults: 640x480, empty target, rate 0.5
        send_box('0, '0, '0, '0, 1'b0, 1'b1);
        send_box(-13'sd4096, -13'sd4096, 12'd4095, 12'd4095, 1'b1, 1'b1);
        send_box(13'sd4095, 13'sd4095, 12'd0, 12'd0, 1'b1, 1'b1);
        // tie on the image center, closed by an empty marker
        send_box(13'sd300, 13'sd220, 12'd40, 12'd40, 1'b1, 1'b0);
        send_box(13'sd310, 13'sd230, 12'd20, 12'd20, 1'b1, 1'b0);
        send_box('0, '0, '0, '0, 1'b0, 1'b1);
        // ignored request mid-frame, nearer box on the closing request
        send_box('0, '0, 12'd100, 12'd100, 1'b1, 1'b0);
        send_box(13'sd4095, -13'sd4096, 12'd4095, 12'd4095, 1'b0, 1'b0);
        send_box(13'sd320, 13'sd240, 12'd1, 12'd1, 1'b1, 1'b1);
        quiesce();
        set_config(640, 480, 100, 100, 200, 200, 32768);
        // fully inside, exactly half, disjoint, touching edge
        send_box(13'sd150, 13'sd150, 12'd50, 12'd50, 1'b1, 1'b1);
        send_box('0, 13'sd100, 12'd200, 12'd200, 1'b1, 1'b1);
        send_box(13'sd400, 13'sd400, 12'd10, 12'd10, 1'b1, 1'b1);
        send_box(13'sd300, 13'sd100, 12'd10, 12'd10, 1'b1, 1'b1);
        quiesce();
        // rate of exactly 1.0 is never exceeded
        set_config(4095, 4095, 0, 0, 4095, 4095, 65536);
        send_box(13'sd10, 13'sd10, 12'd20, 12'd20, 1'b1, 1'b1);
        quiesce();
        // zero rate: a single pixel of overlap is enough
        cfg_write(cbso_pkg::REG_MIN_RATE, '0);
        send_box(13'sd4094, 13'sd4094, 12'd100, 12'd100, 1'b1, 1'b1);
        quiesce();
        // rate far above 1.0
        cfg_write(cbso_pkg::REG_MIN_RATE, {CFG_W{1'b1}});
        send_box(13'sd10, 13'sd10, 12'd20, 12'd20, 1'b1, 1'b1);
        quiesce();
        // smallest frame; upper data bits beyond the register width are dropped
        cfg_write(cbso_pkg::REG_IMAGE_WIDTH, 17'h1F001);
        cfg_write(cbso_pkg::REG_IMAGE_HEIGHT, 17'd1);
        send_box(-13'sd1, -13'sd1, 12'd1, 12'd1, 1'b1, 1'b0);
        send_box('0, '0, 12'd1, 12'd1, 1'b1, 1'b1);
        quiesce();
    endtask

    // Random frames over several register settings and stall levels
    task automatic test_random_frames();
        logic signed [CB:0] x, y, px, py;
        logic [CB-1:0]      w, h, pw, ph;
        int goal, kind, nbox;
        bit tail_close;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            quiesce();
            case (p % 4)
                0: set_config($urandom_range(1, 4095), $urandom_range(1, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 65536));
                1: set_config(1, 1, 0, 0, 0, 0, 0);
                2: set_config(4095, 4095, 0, 0, 4095, 4095, 65536);
                default: set_config($urandom_range(1, 4095), $urandom_range(1, 4095),
                                    $urandom_range(0, 2047), $urandom_range(0, 2047),
                                    $urandom_range(1, 512), $urandom_range(1, 512),
                                    (p == 3) ? $urandom_range(65537, 131071)
                                             : $urandom_range(0, 65536));
            endcase
            stall_pct = (p == 3) ? 0 : 10 * int'($urandom_range(0, 6));
            gaps_on = (p != 5);
            burst_left = 0;
            goal = n_counted + RANDOM_ITEMS / RANDOM_PHASES;
            while (n_counted < goal)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    // noise request
                    random_box(x, y, w, h);
                    pace();
                    send_box(x, y, w, h, 1'($urandom), 1'($urandom));
                end
                else if (kind == 1)
                begin
                    // broken frame: only empty markers
                    repeat ($urandom_range(0, 2))
                    begin
                        pace();
                        send_box(13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom),
                                 1'b0, 1'b0);
                    end
                    pace();
                    send_box(13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom),
                             1'b0, 1'b1);
                end
                else
                begin
                    nbox = $urandom_range(1, 5);
                    tail_close = ($urandom_range(0, 4) == 0);
                    px = '0;
                    py = '0;
                    pw = '0;
                    ph = '0;
                    for (int b = 0; b < nbox; b++)
                    begin
                        random_box(x, y, w, h);
                        // same center as the previous box: a tie
                        if (b > 0 && pw >= 2 && $urandom_range(0, 4) == 0)
                        begin
                            x = px + 13'sd1;
                            y = py;
                            w = pw - 12'd2;
                            h = ph;
                        end
                        pace();
                        send_box(x, y, w, h, 1'b1, (b == nbox - 1) && !tail_close);
                        if ($urandom_range(0, 9) == 0)
                        begin
                            pace();
                            send_box(13'($urandom), 13'($urandom), 12'($urandom),
                                     12'($urandom), 1'b0, 1'b0);
                        end
                        px = x;
                        py = y;
                        pw = w;
                        ph = h;
                    end
                    if (tail_close)
                    begin
                        pace();
                        send_box(13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom),
                                 1'b0, 1'b1);
                    end
                end
            end
        end
    endtask

    // Receiver holds off while requests keep coming, then the sender waits for a full drain
    task automatic test_backpressure();
        logic signed [CB:0] x, y;
        logic [CB-1:0]      w, h;
        quiesce();
        set_config(640, 480, 200, 150, 240, 180, 40000);
        stall_pct = 0;
        gaps_on = 1'b0;
        hold_left = 300;
        repeat (15)
        begin
            for (int b = 0; b < 3; b++)
            begin
                random_box(x, y, w, h);
                send_box(x, y, w, h, 1'b1, b == 2);
            end
        end
        quiesce();
        stall_pct = 40;
        gaps_on = 1'b1;
        repeat (10)
        begin
            random_box(x, y, w, h);
            pace();
            send_box(x, y, w, h, 1'b1, 1'b1);
        end
    endtask

    // Result stall pattern: random runs, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_run = $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        face_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_faces.size() == 0)
            begin
                $error("result with no frame pending");
                errors++;
            end
            else
            begin
                exp_r = pending_faces.pop_front();
                if (face_found !== exp_r.face_found)
                begin
                    $error("face_found: expected %0d, got %0d", exp_r.face_found, face_found);
                    errors++;
                end
                if (in_box !== exp_r.in_box)
                begin
                    $error("in_box: expected %0d, got %0d", exp_r.in_box, in_box);
                    errors++;
                end
                if (face_x !== exp_r.x)
                begin
                    $error("face_x: expected %0d, got %0d", exp_r.x, face_x);
                    errors++;
                end
                if (face_y !== exp_r.y)
                begin
                    $error("face_y: expected %0d, got %0d", exp_r.y, face_y);
                    errors++;
                end
                if (face_w !== exp_r.w)
                begin
                    $error("face_w: expected %0d, got %0d", exp_r.w, face_w);
                    errors++;
                end
                if (face_h !== exp_r.h)
                begin
                    $error("face_h: expected %0d, got %0d", exp_r.h, face_h);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        box_x     = '0;
        box_y     = '0;
        box_w     = '0;
        box_h     = '0;
        box_valid = 1'b0;
        last_box  = 1'b0;
        out_stall = 1'b0;
        img_w     = CB'(cbso_pkg::IMAGE_WIDTH_RESET);
        img_h     = CB'(cbso_pkg::IMAGE_HEIGHT_RESET);
        tgt_x     = '0;
        tgt_y     = '0;
        tgt_w     = '0;
        tgt_h     = '0;
        min_rate  = cbso_pkg::RATE_RESET;
        fr_have   = 1'b0;
        fr_dist   = 0;
        fr_x      = '0;
        fr_y      = '0;
        fr_w      = '0;
        fr_h      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_frames();
        test_backpressure();

        // final drain, bounded
        @(negedge clk);
        in_valid <= 1'b0;
        for (int c = 0; c < 5000 && pending_faces.size() != 0; c++)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (pending_faces.size() != 0)
        begin
            $error("%0d predicted results never delivered", pending_faces.size());
            errors++;
        end

        $display("Sent %0d requests in %0d frames (%0d with a face, %0d in the target box),",
                 n_items, n_frames, n_faces, n_inbox);
        $display("over %0d register writes, with bursty input and stalled output.", n_cfg);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
